@@ src/beat_rate_sync_timer_defines.svh @@
// ----------------------------------------------------------------------------
// Beat rate sync timer: assertion macros
// Shared assertion forms, all sampled on i_clk and idle while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BEAT_RATE_SYNC_TIMER_DEFINES_SVH
`define BEAT_RATE_SYNC_TIMER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BRST_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BRST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/brst_pkg.sv @@
// ----------------------------------------------------------------------------
// Beat rate sync timer package
// Widths, request kinds, register indexes and reset values of the timer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package brst_pkg;

    // Width of every counter and of the beat period.
    localparam int CNT_W     = 32;
    // Bits of the iteration counter of the serial units.
    localparam int CNT_IDX_W = $clog2(CNT_W);
    // Configuration register width and index width.
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    // Stream data widths, rounded up to whole bytes.
    localparam int IN_W      = ((CNT_W + 7) / 8) * 8;
    localparam int OUT_W     = ((1 + 3 * CNT_W + 7) / 8) * 8;
    localparam int REQ_W     = 2;

    // Request kinds carried in the input tuser.
    typedef enum logic [REQ_W-1:0] {
        REQ_TICK  = 2'd0,
        REQ_EVENT = 2'd1,
        REQ_SYNC  = 2'd2,
        REQ_READ  = 2'd3
    } t_req;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_PERIOD    = 2'd2;

    // Register values after reset.
    localparam logic [CFG_W-1:0] RST_MIN_PERIOD     = 16'd25;
    localparam logic [CFG_W-1:0] RST_DEFAULT_PERIOD = 16'd50;
    localparam logic [CFG_W-1:0] RST_SLOW_PERIOD    = 16'd100;

endpackage

`default_nettype wire

@@ src/brst_mul.sv @@
// ----------------------------------------------------------------------------
// Serial multiplier
// Shift-and-add product of two counters, one multiplier bit per cycle,
// truncated to the counter width.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module brst_mul (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [brst_pkg::CNT_W-1:0] i_a,
    input  wire logic [brst_pkg::CNT_W-1:0] i_b,
    output logic                          o_done,
    output logic [brst_pkg::CNT_W-1:0]    o_prod
);
    import brst_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_IDX_W-1:0] r_cnt;
    logic [CNT_W-1:0]     r_acc;
    logic [CNT_W-1:0]     r_mcand;
    logic [CNT_W-1:0]     r_mplier;

    // Control: count down through the multiplier bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_IDX_W'(CNT_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Datapath: the multiplicand shifts up, the multiplier shifts down.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc    <= '0;
            r_mcand  <= i_a;
            r_mplier <= i_b;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= {r_mcand[CNT_W-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[CNT_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

`default_nettype wire

@@ src/brst_div.sv @@
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division of two counters, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module brst_div (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [brst_pkg::CNT_W-1:0] i_dividend,
    input  wire logic [brst_pkg::CNT_W-1:0] i_divisor,
    output logic                          o_done,
    output logic [brst_pkg::CNT_W-1:0]    o_quo
);
    import brst_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_IDX_W-1:0] r_cnt;
    logic [CNT_W-1:0]     r_rem;
    logic [CNT_W-1:0]     r_quo;
    logic [CNT_W-1:0]     r_dsor;
    logic [CNT_W:0]       shifted;
    logic [CNT_W:0]       diff;

    // Trial subtraction of the divisor from the shifted partial remainder.
    always_comb begin
        shifted = {r_rem, r_quo[CNT_W-1]};
        diff    = shifted - {1'b0, r_dsor};
    end

    // Control: count down through the quotient bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_IDX_W'(CNT_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Datapath: dividend bits shift out of the top as quotient bits enter below.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quo  <= i_dividend;
            r_dsor <= i_divisor;
        end else if (r_busy) begin
            if (!diff[CNT_W]) begin
                r_rem <= diff[CNT_W-1:0];
                r_quo <= {r_quo[CNT_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted[CNT_W-1:0];
                r_quo <= {r_quo[CNT_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

@@ src/beat_rate_sync_timer.sv @@
// ----------------------------------------------------------------------------
// Beat rate sync timer
// Keeps a local beat count in step with a remote count carried by sync
// requests. Requests enter on the slave stream: tuser holds the request kind
// (tick, beat event, sync, read), tdata the remote count of a sync. Every
// request gives one result on the master stream. The config port writes the
// minimum, default and slow periods; the user must write them only while the
// block is idle, which the block itself does not enforce. A tick, a beat
// event, a read and the first sync pass through the execute step alone; a sync
// that keeps or slows the period also passes the compare step; a catch-up sync
// then runs the serial multiplier and, unless the span is zero, the serial
// divider, each one bit per cycle. One request is in flight at a time, so the
// next request is taken only once the result is in the output register. A
// finished result may wait in the output register while the next request is
// accepted.
// Reset loads the register reset values and clears all counters. If the
// receiver stalls, the result holds and the block stops after finishing the
// next request until the output register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "beat_rate_sync_timer_defines.svh"

module beat_rate_sync_timer (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Configuration write port.
    input  wire logic                          i_cfg_we,
    input  wire logic [brst_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [brst_pkg::CFG_W-1:0]    i_cfg_data,
    // Request stream.
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: remote_count [31:0]
    input  wire logic [brst_pkg::IN_W-1:0]     s_axis_tdata,
    // tuser: req_type [1:0]
    input  wire logic [brst_pkg::REQ_W-1:0]    s_axis_tuser,
    // Result stream.
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // tdata: beat_fired [0], beat_count [32:1], period_ms [64:33],
    //        refresh_count [96:65], zero [103:97]
    output logic [brst_pkg::OUT_W-1:0]         m_axis_tdata
);
    import brst_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CMP,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_state;

    t_state           r_state;
    t_req             r_req;
    logic [CNT_W-1:0] r_rcount;
    logic [CFG_W-1:0] r_min_period;
    logic [CFG_W-1:0] r_default_period;
    logic [CFG_W-1:0] r_slow_period;
    logic [CNT_W-1:0] r_local;
    logic [CNT_W-1:0] r_beats_last;
    logic [CNT_W-1:0] r_remote_last;
    logic [CNT_W-1:0] r_period;
    logic [CNT_W-1:0] r_elapsed;
    logic [CNT_W-1:0] r_pending;
    logic             r_synced;
    logic [CNT_W-1:0] r_pred;
    logic [CNT_W-1:0] r_needed;
    logic             r_fired;
    logic [CNT_W-1:0] r_refresh_out;
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;

    logic             s_accept;
    logic [CNT_W-1:0] n_elapsed;
    logic             tick_fire;
    logic [CNT_W-1:0] n_pred;
    logic [CNT_W-1:0] local_delta;
    logic [CNT_W-1:0] min_ext;
    logic [CNT_W-1:0] default_ext;
    logic [CNT_W-1:0] slow_ext;
    logic             mul_start;
    logic             mul_done;
    logic [CNT_W-1:0] mul_prod;
    logic             div_start;
    logic             div_done;
    logic [CNT_W-1:0] div_quo;
    logic             out_free;
    logic [OUT_W-1:0] n_out_data;

    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign out_free      = !r_out_valid || m_axis_tready;

    // Arithmetic for the current request.
    always_comb begin
        n_elapsed   = r_elapsed + 1'b1;
        tick_fire   = (n_elapsed >= r_period);
        n_pred      = {r_rcount[CNT_W-2:0], 1'b0} - r_remote_last;
        local_delta = r_local - r_beats_last;
        min_ext     = {{(CNT_W-CFG_W){1'b0}}, r_min_period};
        default_ext = {{(CNT_W-CFG_W){1'b0}}, r_default_period};
        slow_ext    = {{(CNT_W-CFG_W){1'b0}}, r_slow_period};
        mul_start   = (r_state == ST_CMP) && (r_pred > r_local);
        div_start   = (r_state == ST_MUL) && mul_done && (mul_prod != '0);
    end

    // Result word packing.
    always_comb begin
        n_out_data                    = '0;
        n_out_data[0]                 = r_fired;
        n_out_data[CNT_W:1]           = r_local;
        n_out_data[2*CNT_W:CNT_W+1]   = r_period;
        n_out_data[3*CNT_W:2*CNT_W+1] = r_refresh_out;
    end

    // Catch-up span: period times beats since the last sync.
    brst_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (r_period),
        .i_b     (local_delta),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    // Catch-up period: span over the beats still needed.
    brst_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (mul_prod),
        .i_divisor  (r_needed),
        .o_done     (div_done),
        .o_quo      (div_quo)
    );

    // Sequencer, timer state, registers and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_IDLE;
            r_min_period     <= RST_MIN_PERIOD;
            r_default_period <= RST_DEFAULT_PERIOD;
            r_slow_period    <= RST_SLOW_PERIOD;
            r_local          <= '0;
            r_beats_last     <= '0;
            r_remote_last    <= '0;
            r_period         <= {{(CNT_W-CFG_W){1'b0}}, RST_DEFAULT_PERIOD};
            r_elapsed        <= '0;
            r_pending        <= '0;
            r_synced         <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            // Configuration writes; an index beyond the list is ignored.
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MIN_PERIOD:     r_min_period     <= i_cfg_data;
                    CFG_DEFAULT_PERIOD: r_default_period <= i_cfg_data;
                    CFG_SLOW_PERIOD:    r_slow_period    <= i_cfg_data;
                    default: ;
                endcase
            end

            // A new result fills the output register; a taken one frees it.
            if ((r_state == ST_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (s_accept) begin
                        r_req    <= t_req'(s_axis_tuser);
                        r_rcount <= s_axis_tdata[CNT_W-1:0];
                        r_state  <= ST_EXEC;
                    end
                end

                ST_EXEC: begin
                    // Only a later sync goes on to the compare step.
                    r_fired <= (r_req == REQ_EVENT) || ((r_req == REQ_TICK) && tick_fire);
                    r_state <= ((r_req == REQ_SYNC) && r_synced) ? ST_CMP : ST_DONE;
                    case (r_req)
                        REQ_TICK: begin
                            if (tick_fire) begin
                                r_local       <= r_local + 1'b1;
                                r_pending     <= r_pending + 1'b1;
                                r_refresh_out <= r_pending + 1'b1;
                                r_elapsed     <= '0;
                            end else begin
                                r_elapsed     <= n_elapsed;
                                r_refresh_out <= r_pending;
                            end
                        end
                        REQ_EVENT: begin
                            r_local       <= r_local + 1'b1;
                            r_pending     <= r_pending + 1'b1;
                            r_refresh_out <= r_pending + 1'b1;
                            r_elapsed     <= '0;
                        end
                        REQ_SYNC: begin
                            r_refresh_out <= r_pending;
                            if (!r_synced) begin
                                // The first sync adopts the remote count.
                                r_local       <= r_rcount;
                                r_beats_last  <= r_rcount;
                                r_remote_last <= r_rcount;
                                r_period      <= default_ext;
                                r_synced      <= 1'b1;
                            end else begin
                                r_pred <= n_pred;
                            end
                        end
                        REQ_READ: begin
                            r_refresh_out <= r_pending;
                            r_pending     <= '0;
                        end
                        default: ;
                    endcase
                end

                ST_CMP: begin
                    // Behind: catch up through the multiplier. Ahead: slow down. Level: keep the period.
                    if (r_pred > r_local) begin
                        r_needed      <= r_pred - r_local;
                        r_beats_last  <= r_local;
                        r_remote_last <= r_rcount;
                        r_state       <= ST_MUL;
                    end else if (r_pred < r_local) begin
                        r_beats_last  <= r_local;
                        r_remote_last <= r_rcount;
                        r_period      <= slow_ext;
                        r_state       <= ST_DONE;
                    end else begin
                        r_state <= ST_DONE;
                    end
                end

                ST_MUL: begin
                    if (mul_done) begin
                        if (mul_prod == '0) begin
                            r_period <= default_ext;
                            r_state  <= ST_DONE;
                        end else begin
                            r_state <= ST_DIV;
                        end
                    end
                end

                ST_DIV: begin
                    if (div_done) begin
                        r_period <= (div_quo < min_ext) ? min_ext : div_quo;
                        r_state  <= ST_DONE;
                    end
                end

                ST_DONE: begin
                    if (out_free) begin
                        r_out_data <= n_out_data;
                        r_state    <= ST_IDLE;
                    end
                end

                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // An accepted request is always processed in the following cycle.
    `BRST_ASSERT_NEXT(a_accept_exec, s_accept, r_state == ST_EXEC, "accepted request not executed")
    // A beat from a tick restarts the elapsed counter.
    `BRST_ASSERT_NEXT(a_tick_clear, (r_state == ST_EXEC) && (r_req == REQ_TICK) && tick_fire,
        r_elapsed == '0, "tick beat did not clear elapsed time")
    // The divider starts only with a nonzero span and a nonzero divisor.
    `BRST_ASSERT_NOW(a_div_operands, div_start, (mul_prod != '0) && (r_needed != '0),
        "divider started with a zero operand")
    // Once synced, the block stays synced until reset.
    `BRST_ASSERT_NEXT(a_synced_holds, r_synced, r_synced, "synced flag dropped")

endmodule

`default_nettype wire
